// ----- rtl/core/scp_pkg.sv -----
package scp_pkg;

    // Number formats of the angle and of the results.
    localparam int ANGLE_FRAC_BITS = 24;
    localparam int OUT_FRAC_BITS   = 30;

    // Internal word widths.
    localparam int ACC_W = 32;
    localparam int Y2_W  = 32;
    localparam int Y30_W = 32;

    // Rounding shift from Q30 to the output format.
    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
    localparam longint OUT_HALF = (OUT_SHIFT == 0) ? 64'sd0 : (64'sd1 <<< (OUT_SHIFT - 1));

    // Range reduction constants: 1/(2*pi) in Q0.32, angles in Q.32, 1.0 in Q30.
    localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
    localparam logic [34:0] TWOPI_Q32  = 35'd26986075409;
    localparam longint      PI_Q32     = 64'sd13493037705;
    localparam longint      HALFPI_Q32 = 64'sd6746518852;
    localparam longint      ONE_Q30    = 64'sd1073741824;

    // Horner evaluation: the seed of each lane and the term added after each step.
    localparam int HORNER_STEPS = 5;

    typedef logic signed [ACC_W-1:0] coef_arr_t [HORNER_STEPS];

    localparam logic signed [ACC_W-1:0] SIN_SEED = -32'sd26;
    localparam logic signed [ACC_W-1:0] COS_SEED = -32'sd280;

    localparam coef_arr_t SIN_ADD = '{
        32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
    };
    localparam coef_arr_t COS_ADD = '{
        32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
    };

    // Payload carried between the Horner stages.
    typedef struct packed {
        logic signed [ACC_W-1:0] acc_s;
        logic signed [ACC_W-1:0] acc_c;
        logic        [Y2_W-1:0]  y2;
        logic signed [Y30_W-1:0] y30;
        logic                    flip;
    } hstage_t;

endpackage

// ----- rtl/core/sin_cos_polynomial_unit.sv -----
// Channel  Direction  Handshake           Payload
// input    in         in_valid/in_stall   angle (signed Q8.24 radians)
// output   out        out_valid/out_stall sin_value, cos_value (signed, 30 fraction bits)
//
// One transaction enters per clock while in_stall is low; the pipeline has six reduction
// stages, two stages per Horner multiply for five steps, and three output stages.
// Every multiplier is followed by a register, which fixes the stage count.
// rst_n clears only the valid bits of the stages, asynchronously.
// A stall at the output holds only the stages that carry a valid transaction, so
// bubbles close up and the input stays open until all 19 stages are full.
module sin_cos_polynomial_unit
    import scp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sin_value,
    output logic signed [31:0] cos_value
);

    // Pipeline links: index 0 comes out of the range reduction, index HORNER_STEPS
    // goes into the output stage.
    hstage_t link_data  [HORNER_STEPS+1];
    logic    link_valid [HORNER_STEPS+1];
    logic    link_stall [HORNER_STEPS+1];

    // Whole-turn reduction, quadrant fold, rounding to Q30 and squaring.
    scp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .out_valid (link_valid[0]),
        .out_stall (link_stall[0]),
        .out_data  (link_data[0])
    );

    // Sine and cosine polynomials run side by side, one Horner step per module.
    // The last step adds 1.0 to both lanes.
    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        scp_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_stall  (link_stall[k]),
            .in_data   (link_data[k]),
            .add_s     (SIN_ADD[k]),
            .add_c     (COS_ADD[k]),
            .out_valid (link_valid[k+1]),
            .out_stall (link_stall[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    // Final multiply by y for the sine, cosine sign, saturation and output rounding.
    scp_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[HORNER_STEPS]),
        .in_stall  (link_stall[HORNER_STEPS]),
        .in_data   (link_data[HORNER_STEPS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sin_value (sin_value),
        .cos_value (cos_value)
    );

endmodule

// ----- rtl/core/scp_reduce.sv -----
module scp_reduce
    import scp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          angle,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hstage_t                     out_data
);

    localparam int TSH  = ANGLE_FRAC_BITS + 32;
    localparam int A_SH = 32 - ANGLE_FRAC_BITS;
    localparam int T_W  = 30 - ANGLE_FRAC_BITS;
    localparam int YF_W = 66 - ANGLE_FRAC_BITS;
    localparam int Y_W  = 36;
    localparam logic signed [Y_W-1:0] PI_C     = Y_W'(PI_Q32);
    localparam logic signed [Y_W-1:0] HALFPI_C = Y_W'(HALFPI_Q32);
    localparam logic signed [Y30_W-1:0] Y30_MAX = Y30_W'((HALFPI_Q32 + 64'sd2) >>> 2);

    // Stage 1: magnitude of the angle times 1/(2*pi).
    logic               v1_reg;
    logic signed [31:0] a1_reg;
    logic [61:0]        prod1_reg;
    logic [31:0]        ma;
    // Stage 2: rounded turn count.
    logic               v2_reg;
    logic signed [31:0] a2_reg;
    logic [T_W-1:0]     t2_reg;
    logic [62:0]        tsum;
    // Stage 3: remainder after whole turns.
    logic                  v3_reg;
    logic signed [Y_W-1:0] y3_reg;
    logic signed [YF_W-1:0] ash;
    logic signed [YF_W-1:0] yfull;
    logic [T_W+34:0]       prodq;
    // Stage 4: folded and rounded to Q30.
    logic                    v4_reg;
    logic signed [Y30_W-1:0] y30_4_reg;
    logic                    flip4_reg;
    logic signed [Y_W-1:0]   yf;
    logic                    flip_next;
    logic [Y_W-1:0]          ymag;
    logic [Y_W-1:0]          yrnd;
    logic signed [Y30_W-1:0] y30_next;
    // Stage 5: square of y30.
    logic                    v5_reg;
    logic [63:0]             sq5_reg;
    logic signed [Y30_W-1:0] y30_5_reg;
    logic                    flip5_reg;
    logic [Y30_W-1:0]        y30_mag;
    // Stage 6: rounded square.
    logic                    v6_reg;
    logic [Y2_W-1:0]         y2_6_reg;
    logic signed [Y30_W-1:0] y30_6_reg;
    logic                    flip6_reg;
    logic [63:0]             sq_rnd;

    logic stall1, stall2, stall3, stall4, stall5, stall6;

    assign stall6   = v6_reg && out_stall;
    assign stall5   = v5_reg && stall6;
    assign stall4   = v4_reg && stall5;
    assign stall3   = v3_reg && stall4;
    assign stall2   = v2_reg && stall3;
    assign stall1   = v1_reg && stall2;
    assign in_stall = stall1;

    always_comb
    begin
        ma   = angle[31] ? 32'(-angle) : 32'(angle);
        tsum = {1'b0, prod1_reg} + (63'd1 << (TSH - 1));
        ash   = YF_W'(a2_reg) <<< A_SH;
        prodq = t2_reg * TWOPI_Q32;
        if (a2_reg[31])
        begin
            yfull = ash + $signed({1'b0, prodq});
        end
        else
        begin
            yfull = ash - $signed({1'b0, prodq});
        end
        // Fold into [-pi/2, pi/2]; the exact boundary is left alone.
        if (y3_reg > HALFPI_C)
        begin
            yf        = PI_C - y3_reg;
            flip_next = 1'b1;
        end
        else if (y3_reg < -HALFPI_C)
        begin
            yf        = -PI_C - y3_reg;
            flip_next = 1'b1;
        end
        else
        begin
            yf        = y3_reg;
            flip_next = 1'b0;
        end
        ymag     = yf[Y_W-1] ? Y_W'(-yf) : Y_W'(yf);
        yrnd     = (ymag + Y_W'(2)) >> 2;
        y30_next = yf[Y_W-1] ? -$signed(yrnd[Y30_W-1:0]) : $signed(yrnd[Y30_W-1:0]);
        y30_mag  = y30_4_reg[Y30_W-1] ? Y30_W'(-y30_4_reg) : Y30_W'(y30_4_reg);
        sq_rnd   = (sq5_reg + (64'd1 << 29)) >> 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (!stall1) v1_reg <= in_valid;
            if (!stall2) v2_reg <= v1_reg;
            if (!stall3) v3_reg <= v2_reg;
            if (!stall4) v4_reg <= v3_reg;
            if (!stall5) v5_reg <= v4_reg;
            if (!stall6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !stall1)
        begin
            a1_reg    <= angle;
            prod1_reg <= ma * INV2PI_Q32;
        end
        if (v1_reg && !stall2)
        begin
            a2_reg <= a1_reg;
            t2_reg <= T_W'(tsum >> TSH);
        end
        if (v2_reg && !stall3)
        begin
            y3_reg <= yfull[Y_W-1:0];
        end
        if (v3_reg && !stall4)
        begin
            y30_4_reg <= y30_next;
            flip4_reg <= flip_next;
        end
        if (v4_reg && !stall5)
        begin
            sq5_reg   <= y30_mag * y30_mag;
            y30_5_reg <= y30_4_reg;
            flip5_reg <= flip4_reg;
        end
        if (v5_reg && !stall6)
        begin
            y2_6_reg  <= sq_rnd[Y2_W-1:0];
            y30_6_reg <= y30_5_reg;
            flip6_reg <= flip5_reg;
        end
    end

    assign out_valid      = v6_reg;
    assign out_data.acc_s = SIN_SEED;
    assign out_data.acc_c = COS_SEED;
    assign out_data.y2    = y2_6_reg;
    assign out_data.y30   = y30_6_reg;
    assign out_data.flip  = flip6_reg;

    // After folding the reduced angle never leaves [-pi/2, pi/2].
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (y30_4_reg <= Y30_MAX && y30_4_reg >= -Y30_MAX))
        else $error("folded angle out of range");

    // Stage 3 keeps its transaction while it is stalled.
    a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && stall4) |=> (v3_reg && $stable(y3_reg)))
        else $error("stage 3 lost a stalled transaction");

endmodule

// ----- rtl/core/scp_horner_step.sv -----
module scp_horner_step
    import scp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hstage_t                 in_data,
    input  logic signed [ACC_W-1:0] add_s,
    input  logic signed [ACC_W-1:0] add_c,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hstage_t                 out_data
);

    logic                    v1_reg;
    logic [63:0]             prod_s_reg;
    logic [63:0]             prod_c_reg;
    logic                    neg_s_reg;
    logic                    neg_c_reg;
    logic [Y2_W-1:0]         y2_1_reg;
    logic signed [Y30_W-1:0] y30_1_reg;
    logic                    flip1_reg;
    logic                    v2_reg;
    hstage_t                 d2_reg;

    logic [ACC_W-1:0]        mag_s;
    logic [ACC_W-1:0]        mag_c;
    logic [63:0]             rnd_s;
    logic [63:0]             rnd_c;
    logic signed [34:0]      term_s;
    logic signed [34:0]      term_c;
    logic signed [34:0]      sum_s;
    logic signed [34:0]      sum_c;
    logic                    stall1, stall2;

    assign stall2   = v2_reg && out_stall;
    assign stall1   = v1_reg && stall2;
    assign in_stall = stall1;

    always_comb
    begin
        mag_s  = in_data.acc_s[ACC_W-1] ? ACC_W'(-in_data.acc_s) : ACC_W'(in_data.acc_s);
        mag_c  = in_data.acc_c[ACC_W-1] ? ACC_W'(-in_data.acc_c) : ACC_W'(in_data.acc_c);
        rnd_s  = (prod_s_reg + (64'd1 << 29)) >> 30;
        rnd_c  = (prod_c_reg + (64'd1 << 29)) >> 30;
        term_s = neg_s_reg ? -$signed({1'b0, rnd_s[33:0]}) : $signed({1'b0, rnd_s[33:0]});
        term_c = neg_c_reg ? -$signed({1'b0, rnd_c[33:0]}) : $signed({1'b0, rnd_c[33:0]});
        sum_s  = term_s + 35'(add_s);
        sum_c  = term_c + 35'(add_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (!stall1) v1_reg <= in_valid;
            if (!stall2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !stall1)
        begin
            prod_s_reg <= mag_s * in_data.y2;
            prod_c_reg <= mag_c * in_data.y2;
            neg_s_reg  <= in_data.acc_s[ACC_W-1];
            neg_c_reg  <= in_data.acc_c[ACC_W-1];
            y2_1_reg   <= in_data.y2;
            y30_1_reg  <= in_data.y30;
            flip1_reg  <= in_data.flip;
        end
        if (v1_reg && !stall2)
        begin
            d2_reg.acc_s <= sum_s[ACC_W-1:0];
            d2_reg.acc_c <= sum_c[ACC_W-1:0];
            d2_reg.y2    <= y2_1_reg;
            d2_reg.y30   <= y30_1_reg;
            d2_reg.flip  <= flip1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

endmodule

// ----- rtl/core/scp_output.sv -----
module scp_output
    import scp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hstage_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sin_value,
    output logic signed [31:0] cos_value
);

    localparam logic signed [34:0] ONE_C = 35'(ONE_Q30);
    localparam logic signed [31:0] OUT_ONE = 32'sd1 <<< OUT_FRAC_BITS;

    logic               v1_reg;
    logic [63:0]        prod1_reg;
    logic               neg1_reg;
    logic signed [32:0] c1_reg;
    logic               v2_reg;
    logic signed [34:0] s2_reg;
    logic signed [32:0] c2_reg;
    logic               v3_reg;
    logic signed [31:0] sin3_reg;
    logic signed [31:0] cos3_reg;

    logic [ACC_W-1:0]   mag_h;
    logic [Y30_W-1:0]   mag_y;
    logic [63:0]        rnd;
    logic signed [32:0] c_ext;
    logic               stall1, stall2, stall3;

    // Clamp a Q30 value to +-1.0 and round it to the output format.
    function automatic logic signed [31:0] sat_round(input logic signed [34:0] v);
        logic signed [34:0] cl;
        logic [34:0]        m;
        logic [34:0]        r;
        begin
            if (v > ONE_C)
            begin
                cl = ONE_C;
            end
            else if (v < -ONE_C)
            begin
                cl = -ONE_C;
            end
            else
            begin
                cl = v;
            end
            m = cl[34] ? 35'(-cl) : 35'(cl);
            r = (m + 35'(OUT_HALF)) >> OUT_SHIFT;
            sat_round = cl[34] ? -$signed(r[31:0]) : $signed(r[31:0]);
        end
    endfunction

    assign stall3   = v3_reg && out_stall;
    assign stall2   = v2_reg && stall3;
    assign stall1   = v1_reg && stall2;
    assign in_stall = stall1;

    always_comb
    begin
        mag_h = in_data.acc_s[ACC_W-1] ? ACC_W'(-in_data.acc_s) : ACC_W'(in_data.acc_s);
        mag_y = in_data.y30[Y30_W-1] ? Y30_W'(-in_data.y30) : Y30_W'(in_data.y30);
        c_ext = 33'(in_data.acc_c);
        rnd   = (prod1_reg + (64'd1 << 29)) >> 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!stall1) v1_reg <= in_valid;
            if (!stall2) v2_reg <= v1_reg;
            if (!stall3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !stall1)
        begin
            prod1_reg <= mag_h * mag_y;
            neg1_reg  <= in_data.acc_s[ACC_W-1] != in_data.y30[Y30_W-1];
            c1_reg    <= in_data.flip ? -c_ext : c_ext;
        end
        if (v1_reg && !stall2)
        begin
            s2_reg <= neg1_reg ? -$signed({1'b0, rnd[33:0]}) : $signed({1'b0, rnd[33:0]});
            c2_reg <= c1_reg;
        end
        if (v2_reg && !stall3)
        begin
            sin3_reg <= sat_round(s2_reg);
            cos3_reg <= sat_round(35'(c2_reg));
        end
    end

    assign out_valid = v3_reg;
    assign sin_value = sin3_reg;
    assign cos_value = cos3_reg;

    a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sin_value <= OUT_ONE && sin_value >= -OUT_ONE))
        else $error("sine result beyond full scale");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cos_value <= OUT_ONE && cos_value >= -OUT_ONE))
        else $error("cosine result beyond full scale");

endmodule

// ----- test/sin_cos_polynomial_unit_tb.sv -----
`timescale 1ns / 100ps

module sin_cos_polynomial_unit_tb;

    // Number formats follow the package so that the predictor tracks the build.
    localparam int ANG_FB = scp_pkg::ANGLE_FRAC_BITS;
    localparam int OUT_FB = scp_pkg::OUT_FRAC_BITS;

    // Range-reduction constants: 1/(2*pi) in Q0.32, the angles in Q.32.
    localparam longint unsigned INV_TWO_PI = 64'd683565276;
    localparam longint TWO_PI_Q32  = 64'sd26986075409;
    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint HALF_PI_Q32 = 64'sd6746518852;
    localparam longint UNIT_Q30    = 64'sd1073741824;

    // Angle codes in Q8.24 that sit on interesting spots of the reduction.
    localparam int HALF_PI_ANGLE = 26353589;
    localparam int TWO_PI_ANGLE  = 105414357;
    // With four whole turns removed, this angle leaves y exactly on -pi/2 (and
    // its negation exactly on +pi/2), which must not be folded.
    localparam int FOLD_EDGE_ANGLE = 395303839;

    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 50;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } trig_expect_t;

    // Scoreboard: predicts sine and cosine for every accepted angle and checks
    // the results in arrival order (the block keeps transactions in order).
    class sincos_scoreboard;
        trig_expect_t trig_q[$];
        int unsigned  errors;
        int unsigned  noted;
        int unsigned  checked;

        function new();
            errors  = 0;
            noted   = 0;
            checked = 0;
        endfunction

        // Divide by 2^sh, rounding half away from zero.
        function automatic longint round_off(longint v, int sh);
            longint unsigned mag;
            mag = (v < 0) ? 64'd0 - $unsigned(v) : $unsigned(v);
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -$signed(mag) : $signed(mag);
        endfunction

        // Product divided by 2^sh, rounded half away from zero on the magnitude.
        function automatic longint mul_round(longint a, longint b, int sh);
            longint unsigned ma;
            longint unsigned mb;
            longint unsigned mag;
            bit neg;
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? 64'd0 - $unsigned(a) : $unsigned(a);
            mb  = (b < 0) ? 64'd0 - $unsigned(b) : $unsigned(b);
            mag = (ma * mb + (64'd1 << (sh - 1))) >> sh;
            return neg ? -$signed(mag) : $signed(mag);
        endfunction

        // Q30 minimax coefficients; index 0 seeds the Horner chain.
        function automatic longint poly_term(bit is_cos, int idx);
            case (idx)
                0: return is_cos ? -64'sd280      : -64'sd26;
                1: return is_cos ? 64'sd26586     : 64'sd2956;
                2: return is_cos ? -64'sd1491253  : -64'sd213040;
                3: return is_cos ? 64'sd44739212  : 64'sd8947846;
                default: return is_cos ? -64'sd536870912 : -64'sd178956974;
            endcase
        endfunction

        function automatic longint horner_eval(bit is_cos, longint y2);
            longint acc;
            int idx;
            acc = poly_term(is_cos, 0);
            for (idx = 1; idx < 5; idx++)
                acc = mul_round(acc, y2, 30) + poly_term(is_cos, idx);
            return mul_round(acc, y2, 30) + UNIT_Q30;
        endfunction

        function automatic logic signed [31:0] to_out_format(longint v);
            if (v > UNIT_Q30)
                v = UNIT_Q30;
            if (v < -UNIT_Q30)
                v = -UNIT_Q30;
            if (OUT_FB < 30)
                v = round_off(v, 30 - OUT_FB);
            return v[31:0];
        endfunction

        function automatic trig_expect_t predict_sincos(logic signed [31:0] ang);
            longint a;
            longint q;
            longint y;
            longint y30;
            longint y2;
            longint s;
            longint c;
            longint unsigned mag;
            longint unsigned turns;
            bit flip;
            trig_expect_t r;
            a     = ang;
            mag   = (a < 0) ? 64'd0 - $unsigned(a) : $unsigned(a);
            turns = (mag * INV_TWO_PI + (64'd1 << (ANG_FB + 31))) >> (ANG_FB + 32);
            q     = (a < 0) ? -$signed(turns) : $signed(turns);
            y     = a * (64'sd1 <<< (32 - ANG_FB)) - q * TWO_PI_Q32;
            flip  = 1'b0;
            if (y > HALF_PI_Q32)
            begin
                y    = PI_Q32 - y;
                flip = 1'b1;
            end
            else if (y < -HALF_PI_Q32)
            begin
                y    = -PI_Q32 - y;
                flip = 1'b1;
            end
            y30 = round_off(y, 2);
            y2  = mul_round(y30, y30, 30);
            s   = mul_round(horner_eval(1'b0, y2), y30, 30);
            c   = horner_eval(1'b1, y2);
            if (flip)
                c = -c;
            r.angle = ang;
            r.sin_v = to_out_format(s);
            r.cos_v = to_out_format(c);
            return r;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void note_angle(logic signed [31:0] ang);
            trig_q.push_back(predict_sincos(ang));
            noted++;
        endfunction

        task check_result(logic signed [31:0] sin_got, logic signed [31:0] cos_got);
            trig_expect_t e;
            checked++;
            if (trig_q.size() == 0)
            begin
                report($sformatf("result sin=%h cos=%h with no angle outstanding",
                                 sin_got, cos_got));
            end
            else
            begin
                e = trig_q.pop_front();
                if (sin_got !== e.sin_v)
                    report($sformatf("angle %h: sin_value %h, predicted %h",
                                     e.angle, sin_got, e.sin_v));
                if (cos_got !== e.cos_v)
                    report($sformatf("angle %h: cos_value %h, predicted %h",
                                     e.angle, cos_got, e.cos_v));
            end
        endtask

        task check_drained();
            if (trig_q.size() != 0)
                report($sformatf("%0d predicted results never came out, first angle %h",
                                 trig_q.size(), trig_q[0].angle));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] angle = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] sin_value;
    logic signed [31:0] cos_value;

    sincos_scoreboard sb = new();

    logic signed [31:0] angle_q[$];
    int unsigned        directed_count;
    int unsigned        cycle_count = 0;
    int unsigned        stall_phases = 0;

    // Receiver stall pattern: it runs in phases of random length, and each phase
    // picks one behavior: open, light random stalls, a periodic stall or heavy
    // back-pressure.
    int unsigned        stall_mode = 0;
    int unsigned        stall_left = 0;

    sin_cos_polynomial_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sin_value (sin_value),
        .cos_value (cos_value)
    );

    always #10 clk = ~clk;

    // Watchdog. The slowest correct run is bounded by heavy receiver stalls on
    // every result plus the sender gaps, well below this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, sb.trig_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side. The handshake is sampled at the edge before any update of
    // this edge lands, so a result is taken exactly when out_valid was high and
    // out_stall low during the previous cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(sin_value, cos_value);
            if (stall_left == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stall_left   = $urandom_range(20, 120);
                stall_phases = stall_phases + 1;
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= (stall_left % 4 == 0);
                default: out_stall <= ($urandom_range(0, 99) < 80);
            endcase
        end
    end

    // Input side. Angles leave in bursts of random length separated by random
    // gaps; a zero gap joins bursts into longer unbroken runs. An offered angle
    // stays on the port, unchanged, until the block takes it.
    task automatic drive_angles();
        int unsigned        next_idx;
        int unsigned        burst_left;
        int unsigned        gap_left;
        bit                 busy;
        logic signed [31:0] cur_angle;
        next_idx   = 0;
        burst_left = 0;
        gap_left   = 0;
        busy       = 1'b0;
        cur_angle  = '0;
        while (next_idx < angle_q.size() || busy)
        begin
            @(posedge clk);
            if (busy && !in_stall)
            begin
                sb.note_angle(cur_angle);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0 || next_idx >= angle_q.size())
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left = gap_left - 1;
                end
                else
                begin
                    cur_angle  = angle_q[next_idx];
                    next_idx   = next_idx + 1;
                    burst_left = burst_left - 1;
                    busy       = 1'b1;
                    in_valid   <= 1'b1;
                    angle      <= cur_angle;
                end
            end
        end
    endtask

    // Directed angles: the field extremes, the fold edges around +-pi/2, whole
    // turns, the exact no-fold boundary, and both sides of the rounding point
    // of the turn count at odd half turns.
    task automatic load_directed();
        longint mid;
        int k;
        angle_q.push_back(32'sd0);
        angle_q.push_back(32'sd1);
        angle_q.push_back(-32'sd1);
        angle_q.push_back(32'sh7FFF_FFFF);
        angle_q.push_back(32'sh8000_0000);
        angle_q.push_back(HALF_PI_ANGLE);
        angle_q.push_back(-HALF_PI_ANGLE);
        angle_q.push_back(HALF_PI_ANGLE + 1);
        angle_q.push_back(-HALF_PI_ANGLE - 1);
        angle_q.push_back(TWO_PI_ANGLE);
        angle_q.push_back(-TWO_PI_ANGLE);
        angle_q.push_back(FOLD_EDGE_ANGLE);
        angle_q.push_back(-FOLD_EDGE_ANGLE);
        angle_q.push_back(FOLD_EDGE_ANGLE + 1);
        angle_q.push_back(-FOLD_EDGE_ANGLE - 1);
        for (k = 0; k < 2; k++)
        begin
            // Largest angle whose turn count still rounds down at (2k+1) half turns.
            mid = ((2 * k + 1) * (64'sd1 <<< (ANG_FB + 31))) / $signed(INV_TWO_PI);
            angle_q.push_back(mid[31:0]);
            angle_q.push_back(-mid[31:0]);
            angle_q.push_back(mid[31:0] + 1);
            angle_q.push_back(-mid[31:0] - 1);
        end
        directed_count = angle_q.size();
    endtask

    // Random angles: full 32-bit patterns for bit coverage, a dense band of a
    // few turns where the polynomials do their real work, and angles hugging
    // multiples of pi/2 where folding and saturation happen.
    task automatic load_random();
        int n;
        int m;
        int unsigned pick;
        logic signed [31:0] a;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                a = $urandom;
            else if (pick < 75)
                a = int'($urandom_range(0, 421657428)) - 210828714;
            else
            begin
                m = int'($urandom_range(0, 162)) - 81;
                a = m * HALF_PI_ANGLE + int'($urandom_range(0, 512)) - 256;
            end
            angle_q.push_back(a);
        end
    endtask

    initial
    begin
        load_directed();
        load_random();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        drive_angles();

        // Everything has been accepted; wait for the last results, then give the
        // pipeline its full latency again to catch any stray output.
        while (sb.trig_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();

        $display("Covered %0d angles (%0d directed edge cases, %0d random), %0d results checked.",
                 sb.noted, directed_count, angle_q.size() - directed_count, sb.checked);
        $display("Input sent in bursts with gaps; output stalled over %0d pattern phases; %0d mismatches.",
                 stall_phases, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
